// ----- rtl/core/dsft_pkg.sv -----
// Package for the DShot frame transmitter: word types, configuration
// register indexes, frame constants and the reset values of the registers.
// No dependencies.
`timescale 1ns / 1ps

package dsft_pkg;

	localparam int TICK_COUNT_BITS_DEFAULT = 8;

	localparam int THRUST_W   = 17;
	localparam int TICKS_W    = 8;
	localparam int FRAME_W    = 16;
	localparam int THROTTLE_W = 11;
	localparam int CRC_W      = 4;
	localparam int BITS_W     = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [THRUST_W-1:0]   Q_ONE         = 17'd65536;
	localparam logic [THROTTLE_W-1:0] THROTTLE_BASE = 11'd48;
	localparam logic [THROTTLE_W-1:0] THROTTLE_SPAN = 11'd1999;
	localparam logic [THROTTLE_W-1:0] THROTTLE_MAX  = 11'd2047;
	localparam logic [BITS_W-1:0]     FRAME_BITS    = 5'd16;
	localparam logic [CRC_W-1:0]      CRC_MASK      = 4'hF;

	localparam logic [THRUST_W-1:0] RST_LOWER_LIMIT = 17'd0;
	localparam logic [THRUST_W-1:0] RST_UPPER_LIMIT = 17'd65536;
	localparam logic [TICKS_W-1:0]  RST_ZERO_HIGH   = 8'd10;
	localparam logic [TICKS_W-1:0]  RST_ZERO_LOW    = 8'd12;
	localparam logic [TICKS_W-1:0]  RST_ONE_HIGH    = 8'd16;
	localparam logic [TICKS_W-1:0]  RST_ONE_LOW     = 8'd6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRUST_LOWER = 3'd0,
		CFG_THRUST_UPPER = 3'd1,
		CFG_ZERO_HIGH    = 3'd2,
		CFG_ZERO_LOW     = 3'd3,
		CFG_ONE_HIGH     = 3'd4,
		CFG_ONE_LOW      = 3'd5
	} cfg_reg_e;

	typedef struct packed {
		logic [THRUST_W-1:0] thrust_lower_limit;
		logic [THRUST_W-1:0] thrust_upper_limit;
		logic [TICKS_W-1:0]  zero_high_ticks;
		logic [TICKS_W-1:0]  zero_low_ticks;
		logic [TICKS_W-1:0]  one_high_ticks;
		logic [TICKS_W-1:0]  one_low_ticks;
	} cfg_t;

	typedef struct packed {
		logic                req_type;
		logic [THRUST_W-1:0] thrust;
	} cmd_t;

	typedef struct packed {
		logic               line_level;
		logic [FRAME_W-1:0] frame_word;
		logic               sending;
		logic               frame_end;
	} res_t;

endpackage

// ----- rtl/core/dsft_frame_builder.sv -----
// Frame builder: clamps a Q1.16 thrust, maps it to a DShot throttle value
// and appends the nibble-XOR checksum. Combinational; uses dsft_pkg.
`timescale 1ns / 1ps

module dsft_frame_builder (
	input  logic [dsft_pkg::THRUST_W-1:0] thrust,
	input  dsft_pkg::cfg_t                cfg,
	output logic [dsft_pkg::FRAME_W-1:0]  frame
);

	logic [dsft_pkg::THRUST_W-1:0]   t_lo;
	logic [dsft_pkg::THRUST_W-1:0]   t_hi;
	logic [dsft_pkg::THRUST_W-1:0]   t_sat;
	logic [dsft_pkg::THRUST_W-1:0]   span;
	logic [27:0]                     product;
	logic [dsft_pkg::THROTTLE_W:0]   throttle_sum;
	logic [dsft_pkg::THROTTLE_W-1:0] throttle;
	logic [dsft_pkg::THROTTLE_W:0]   v;
	logic [dsft_pkg::CRC_W-1:0]      crc;

	always_comb begin
		t_lo  = (thrust < cfg.thrust_lower_limit) ? cfg.thrust_lower_limit : thrust;
		t_hi  = (t_lo > cfg.thrust_upper_limit) ? cfg.thrust_upper_limit : t_lo;
		t_sat = (t_hi > dsft_pkg::Q_ONE) ? dsft_pkg::Q_ONE : t_hi;
		span  = dsft_pkg::Q_ONE - t_sat;
		product = 28'(dsft_pkg::THROTTLE_SPAN) * 28'(span);
		throttle_sum = 12'(dsft_pkg::THROTTLE_BASE) + 12'(product[27:16]);
		if (t_sat == '0) begin
			throttle = '0;
		end else if (throttle_sum > 12'(dsft_pkg::THROTTLE_MAX)) begin
			throttle = dsft_pkg::THROTTLE_MAX;
		end else begin
			throttle = throttle_sum[dsft_pkg::THROTTLE_W-1:0];
		end
		v   = {throttle, 1'b0};
		crc = (v[3:0] ^ v[7:4] ^ v[11:8]) & dsft_pkg::CRC_MASK;
		frame = {throttle, 1'b0, crc};
	end

endmodule

// ----- rtl/core/dsft_serializer.sv -----
// Serializer: holds the pending frame and the frame on the line, and steps
// the pulse timing by one tick per accepted tick word. Uses dsft_pkg.
`timescale 1ns / 1ps

module dsft_serializer #(
	parameter int TICK_COUNT_BITS = dsft_pkg::TICK_COUNT_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic                         req_type,
	input  logic [dsft_pkg::FRAME_W-1:0] frame,
	input  dsft_pkg::cfg_t               cfg,
	output dsft_pkg::res_t               res
);

	localparam int CW = TICK_COUNT_BITS;
	localparam logic [16:0] CNT_MAX = (17'd1 << CW) - 17'd1;

	logic [dsft_pkg::FRAME_W-1:0] shift_q;
	logic [dsft_pkg::BITS_W-1:0]  bits_q;
	logic [CW-1:0]                ticks_q;
	logic                         high_q;
	logic [dsft_pkg::FRAME_W-1:0] pend_word_q;
	logic                         pend_v_q;

	logic [dsft_pkg::FRAME_W-1:0] shift_d;
	logic [dsft_pkg::BITS_W-1:0]  bits_d;
	logic [CW-1:0]                ticks_d;
	logic                         high_d;
	logic [dsft_pkg::FRAME_W-1:0] pend_word_d;
	logic                         pend_v_d;

	logic                         load;
	logic [dsft_pkg::FRAME_W-1:0] word_eff;
	logic [dsft_pkg::BITS_W-1:0]  bits_eff;
	logic [dsft_pkg::BITS_W-1:0]  bits_dec;
	logic                         high_eff;
	logic [CW-1:0]                ticks_eff;
	logic [CW-1:0]                ticks_dec;
	logic                         cur_bit;
	logic                         next_bit;

	function automatic logic [CW-1:0] pulse_len(input logic bit_val, input logic high,
			input dsft_pkg::cfg_t c);
		logic [dsft_pkg::TICKS_W-1:0] n;
		logic [16:0]                  n_ext;
		if (bit_val) begin
			n = high ? c.one_high_ticks : c.one_low_ticks;
		end else begin
			n = high ? c.zero_high_ticks : c.zero_low_ticks;
		end
		n_ext = 17'(n);
		if (n_ext == '0) begin
			n_ext = 17'd1;
		end
		if (n_ext > CNT_MAX) begin
			n_ext = CNT_MAX;
		end
		return n_ext[CW-1:0];
	endfunction

	always_comb begin
		load      = (bits_q == '0) && pend_v_q;
		word_eff  = load ? pend_word_q : shift_q;
		bits_eff  = load ? dsft_pkg::FRAME_BITS : bits_q;
		high_eff  = load ? 1'b1 : high_q;
		bits_dec  = bits_eff - 5'd1;
		cur_bit   = word_eff[bits_dec[3:0]];
		next_bit  = word_eff[4'(bits_eff - 5'd2)];
		ticks_eff = load ? pulse_len(cur_bit, 1'b1, cfg) : ticks_q;
		ticks_dec = ticks_eff - CW'(1);

		shift_d     = shift_q;
		bits_d      = bits_q;
		ticks_d     = ticks_q;
		high_d      = high_q;
		pend_word_d = pend_word_q;
		pend_v_d    = pend_v_q;
		res         = '0;

		if (req_type) begin
			pend_word_d    = frame;
			pend_v_d       = 1'b1;
			res.sending    = (bits_q != '0);
			res.line_level = (bits_q != '0) ? high_q : 1'b0;
			res.frame_word = frame;
		end else begin
			if (load) begin
				shift_d  = pend_word_q;
				pend_v_d = 1'b0;
				bits_d   = bits_eff;
				high_d   = 1'b1;
				ticks_d  = ticks_eff;
			end
			if (bits_eff != '0) begin
				res.line_level = high_eff;
				res.frame_word = word_eff;
				res.sending    = 1'b1;
				ticks_d        = ticks_dec;
				if (ticks_dec == '0) begin
					if (high_eff) begin
						high_d  = 1'b0;
						ticks_d = pulse_len(cur_bit, 1'b0, cfg);
					end else begin
						bits_d = bits_dec;
						if (bits_dec != '0) begin
							high_d  = 1'b1;
							ticks_d = pulse_len(next_bit, 1'b1, cfg);
						end else begin
							res.frame_end = 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= '0;
			bits_q      <= '0;
			ticks_q     <= '0;
			high_q      <= 1'b0;
			pend_word_q <= '0;
			pend_v_q    <= 1'b0;
		end else if (fire) begin
			shift_q     <= shift_d;
			bits_q      <= bits_d;
			ticks_q     <= ticks_d;
			high_q      <= high_d;
			pend_word_q <= pend_word_d;
			pend_v_q    <= pend_v_d;
		end
	end

	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= dsft_pkg::FRAME_BITS)
		else $error("bit counter beyond frame length");

	a_end_idles: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.frame_end |=> bits_q == '0)
		else $error("serializer not idle after the last tick of a frame");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !req_type && load |=> !pend_v_q && bits_q != '0)
		else $error("pending frame not taken over by the serializer");

	a_cmd_pends: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_type |=> pend_v_q && pend_word_q == $past(frame))
		else $error("command did not leave its frame pending");

endmodule

// ----- rtl/core/dshot_frame_transmitter.sv -----
// Top level of the DShot frame transmitter: input register, configuration
// registers and output register around dsft_frame_builder and dsft_serializer.
// Uses dsft_pkg.
//
//   channel   direction  handshake               payload
//   cmd       in         cmd_valid / cmd_stall   dsft_pkg::cmd_t
//   res       out        res_valid / res_stall   dsft_pkg::res_t
//   cfg       in         cfg_we                  cfg_index, cfg_data
//
// One word is accepted per clock while cmd_stall is low; its result is registered
// first in the input register and then in the output register.
// The serializer state advances once per word as it leaves the input register.
// Reset clears the serializer state and loads the register defaults.
// A stalled result holds the output register; the input register still takes
// one more word, and cmd_stall rises only when both registers are full.
`timescale 1ns / 1ps

module dshot_frame_transmitter #(
	parameter int TICK_COUNT_BITS = dsft_pkg::TICK_COUNT_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  dsft_pkg::cmd_t                  cmd,
	output logic                            res_valid,
	input  logic                            res_stall,
	output dsft_pkg::res_t                  res,
	input  logic                            cfg_we,
	input  logic [dsft_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dsft_pkg::CFG_DATA_W-1:0] cfg_data
);

	dsft_pkg::cfg_t cfg_q;
	logic           valid_s1;
	dsft_pkg::cmd_t cmd_s1;
	logic           valid_s2;
	dsft_pkg::res_t res_s2;

	logic                         advance;
	logic                         fire;
	logic [dsft_pkg::FRAME_W-1:0] frame;
	dsft_pkg::res_t               res_d;

	assign advance   = !valid_s2 || !res_stall;
	assign fire      = valid_s1 && advance;
	assign cmd_stall = valid_s1 && !advance;
	assign res_valid = valid_s2;
	assign res       = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thrust_lower_limit <= dsft_pkg::RST_LOWER_LIMIT;
			cfg_q.thrust_upper_limit <= dsft_pkg::RST_UPPER_LIMIT;
			cfg_q.zero_high_ticks    <= dsft_pkg::RST_ZERO_HIGH;
			cfg_q.zero_low_ticks     <= dsft_pkg::RST_ZERO_LOW;
			cfg_q.one_high_ticks     <= dsft_pkg::RST_ONE_HIGH;
			cfg_q.one_low_ticks      <= dsft_pkg::RST_ONE_LOW;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dsft_pkg::CFG_THRUST_LOWER: cfg_q.thrust_lower_limit <= cfg_data;
				dsft_pkg::CFG_THRUST_UPPER: cfg_q.thrust_upper_limit <= cfg_data;
				dsft_pkg::CFG_ZERO_HIGH:    cfg_q.zero_high_ticks    <= cfg_data[7:0];
				dsft_pkg::CFG_ZERO_LOW:     cfg_q.zero_low_ticks     <= cfg_data[7:0];
				dsft_pkg::CFG_ONE_HIGH:     cfg_q.one_high_ticks     <= cfg_data[7:0];
				dsft_pkg::CFG_ONE_LOW:      cfg_q.one_low_ticks      <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_d;
		end
	end

	dsft_frame_builder u_frame_builder (
		.thrust (cmd_s1.thrust),
		.cfg    (cfg_q),
		.frame  (frame)
	);

	dsft_serializer #(
		.TICK_COUNT_BITS (TICK_COUNT_BITS)
	) u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.req_type (cmd_s1.req_type),
		.frame    (frame),
		.cfg      (cfg_q),
		.res      (res_d)
	);

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1 && valid_s2 && res_stall)
		else $error("input stalled with room in the pipeline");

	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res_valid)
		else $error("processed word produced no result");

	a_end_sending: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.frame_end |-> res.sending)
		else $error("frame end flagged outside a sending tick");

endmodule

// ----- verif/dshot_frame_transmitter_tb.sv -----
// Self-checking testbench for dshot_frame_transmitter: random and directed
// thrust and tick words, random stalls on both sides, results checked in order.
// Depends on dsft_pkg and the RTL of the block.
`timescale 1ns / 1ps

module dshot_frame_transmitter_tb;

	localparam int TICK_BITS = dsft_pkg::TICK_COUNT_BITS_DEFAULT;
	localparam int TICK_MASK = (1 << TICK_BITS) - 1;
	localparam int unsigned FULL_SCALE = 65536;
	localparam int unsigned THROTTLE_FLOOR = 48;
	localparam int unsigned THROTTLE_SPAN = 1999;
	localparam int unsigned THROTTLE_CAP = 2047;
	localparam int FRAME_LEN = 16;
	localparam int HOLD_CYCLES = 300;

	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_THRUST = 1'b1;
	localparam logic [dsft_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [dsft_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	class dshot_line_tracker;
		dsft_pkg::cfg_t regs;
		logic [dsft_pkg::FRAME_W-1:0] shifter;
		logic [dsft_pkg::FRAME_W-1:0] pend_word;
		bit pend_valid;
		bit high_phase;
		int bits_left;
		int ticks_left;
		dsft_pkg::res_t due_results[$];
		int mismatches;

		function new();
			regs.thrust_lower_limit = 17'd0;
			regs.thrust_upper_limit = 17'd65536;
			regs.zero_high_ticks = 8'd10;
			regs.zero_low_ticks = 8'd12;
			regs.one_high_ticks = 8'd16;
			regs.one_low_ticks = 8'd6;
			shifter = '0;
			pend_word = '0;
			pend_valid = 1'b0;
			high_phase = 1'b0;
			bits_left = 0;
			ticks_left = 0;
			mismatches = 0;
		endfunction

		function void store_reg(logic [dsft_pkg::CFG_IDX_W-1:0] idx,
				logic [dsft_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				dsft_pkg::CFG_THRUST_LOWER: regs.thrust_lower_limit = data;
				dsft_pkg::CFG_THRUST_UPPER: regs.thrust_upper_limit = data;
				dsft_pkg::CFG_ZERO_HIGH:    regs.zero_high_ticks = data[dsft_pkg::TICKS_W-1:0];
				dsft_pkg::CFG_ZERO_LOW:     regs.zero_low_ticks = data[dsft_pkg::TICKS_W-1:0];
				dsft_pkg::CFG_ONE_HIGH:     regs.one_high_ticks = data[dsft_pkg::TICKS_W-1:0];
				dsft_pkg::CFG_ONE_LOW:      regs.one_low_ticks = data[dsft_pkg::TICKS_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [dsft_pkg::FRAME_W-1:0] frame_for(logic [dsft_pkg::THRUST_W-1:0] thrust);
			int unsigned t;
			int unsigned throttle;
			logic [11:0] tel;
			logic [3:0] crc;
			t = thrust;
			if (t < regs.thrust_lower_limit) t = regs.thrust_lower_limit;
			if (t > regs.thrust_upper_limit) t = regs.thrust_upper_limit;
			if (t > FULL_SCALE) t = FULL_SCALE;
			if (t == 0) begin
				throttle = 0;
			end else begin
				throttle = THROTTLE_FLOOR + ((THROTTLE_SPAN * (FULL_SCALE - t)) >> 16);
				if (throttle > THROTTLE_CAP) throttle = THROTTLE_CAP;
			end
			tel = 12'(throttle << 1);
			crc = 4'(tel ^ (tel >> 4) ^ (tel >> 8));
			return 16'((throttle << 5) | crc);
		endfunction

		function int pulse_len(bit high);
			logic [dsft_pkg::TICKS_W-1:0] n;
			int len;
			if (shifter[(bits_left - 1) & 15])
				n = high ? regs.one_high_ticks : regs.one_low_ticks;
			else
				n = high ? regs.zero_high_ticks : regs.zero_low_ticks;
			len = (n == 0) ? 1 : int'(n);
			if (len > TICK_MASK) len = TICK_MASK;
			return len;
		endfunction

		function void accept_word(dsft_pkg::cmd_t w);
			dsft_pkg::res_t r;
			r = '0;
			if (w.req_type == REQ_THRUST) begin
				pend_word = frame_for(w.thrust);
				pend_valid = 1'b1;
				r.sending = (bits_left != 0);
				r.line_level = r.sending ? high_phase : 1'b0;
				r.frame_word = pend_word;
			end else begin
				if (bits_left == 0 && pend_valid) begin
					shifter = pend_word;
					pend_valid = 1'b0;
					bits_left = FRAME_LEN;
					high_phase = 1'b1;
					ticks_left = pulse_len(1'b1);
				end
				if (bits_left != 0) begin
					r.line_level = high_phase;
					r.frame_word = shifter;
					r.sending = 1'b1;
					ticks_left = (ticks_left - 1) & TICK_MASK;
					if (ticks_left == 0) begin
						if (high_phase) begin
							high_phase = 1'b0;
							ticks_left = pulse_len(1'b0);
						end else begin
							bits_left = bits_left - 1;
							if (bits_left != 0) begin
								high_phase = 1'b1;
								ticks_left = pulse_len(1'b1);
							end else begin
								r.frame_end = 1'b1;
							end
						end
					end
				end
			end
			due_results.push_back(r);
		endfunction

		function void flag(string field, logic [dsft_pkg::FRAME_W-1:0] want,
				logic [dsft_pkg::FRAME_W-1:0] got);
			$display("%0t: %s expected %h actual %h", $time, field, want, got);
			mismatches++;
		endfunction

		function void match_result(dsft_pkg::res_t got);
			dsft_pkg::res_t want;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected word, expected none actual %h", $time, got);
				mismatches++;
				return;
			end
			want = due_results.pop_front();
			if (got.line_level !== want.line_level)
				flag("line_level", want.line_level, got.line_level);
			if (got.frame_word !== want.frame_word)
				flag("frame_word", want.frame_word, got.frame_word);
			if (got.sending !== want.sending)
				flag("sending", want.sending, got.sending);
			if (got.frame_end !== want.frame_end)
				flag("frame_end", want.frame_end, got.frame_end);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	dsft_pkg::cmd_t cmd;
	logic res_valid;
	logic res_stall;
	dsft_pkg::res_t res;
	logic cfg_we;
	logic [dsft_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dsft_pkg::CFG_DATA_W-1:0] cfg_data;

	bit idle_on = 1'b1;
	bit pressure_armed = 1'b0;
	dshot_line_tracker tracker = new();

	dshot_frame_transmitter #(
		.TICK_COUNT_BITS(TICK_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : receiver
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_armed) begin
				pressure_armed = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			res_stall <= idle_on && ($urandom_range(0, 99) < 16);
		end
	end

	always @(posedge clk) begin
		if (res_valid === 1'b1 && res_stall === 1'b0)
			tracker.match_result(res);
	end

	function automatic logic [dsft_pkg::THRUST_W-1:0] pick_thrust();
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return 17'd1;
			2: return 17'd65535;
			3: return 17'd65536;
			4: return 17'h1FFFF;
			5: return 17'($urandom);
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic send_word(input logic req, input logic [dsft_pkg::THRUST_W-1:0] thrust);
		dsft_pkg::cmd_t w;
		w.req_type = req;
		w.thrust = thrust;
		if (idle_on && $urandom_range(0, 99) < 16) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (cmd_stall);
		tracker.accept_word(w);
		@(negedge clk);
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		while (tracker.due_results.size() != 0) @(negedge clk);
	endtask

	task automatic load_config(input logic [dsft_pkg::CFG_DATA_W-1:0] lower, upper,
			zero_hi, zero_lo, one_hi, one_lo, input bit with_spare);
		logic [dsft_pkg::CFG_IDX_W-1:0] idx [8];
		logic [dsft_pkg::CFG_DATA_W-1:0] val [8];
		int n;
		idx = '{dsft_pkg::CFG_THRUST_LOWER, dsft_pkg::CFG_THRUST_UPPER,
			dsft_pkg::CFG_ZERO_HIGH, dsft_pkg::CFG_ZERO_LOW,
			dsft_pkg::CFG_ONE_HIGH, dsft_pkg::CFG_ONE_LOW, CFG_SPARE_LO, CFG_SPARE_HI};
		val = '{lower, upper, zero_hi, zero_lo, one_hi, one_lo, 17'h1FFFF, 17'h0};
		n = with_spare ? 8 : 6;
		for (int i = 0; i < n; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			tracker.store_reg(idx[i], val[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_mix(input int count, input int cmd_odds);
		int sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(1, cmd_odds) == 1) begin
				repeat ($urandom_range(1, 3)) begin
					send_word(REQ_THRUST, pick_thrust());
					sent++;
				end
			end else begin
				send_word(REQ_TICK, 17'($urandom));
				sent++;
			end
		end
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_word(REQ_TICK, 17'($urandom));
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: ticks on an idle line, a frame started from the
		// pending slot, and commands that replace the pending frame mid-send.
		send_word(REQ_TICK, 17'h1FFFF);
		send_word(REQ_THRUST, 17'd65536);
		repeat (3) send_word(REQ_TICK, 17'd0);
		send_word(REQ_THRUST, 17'd0);
		send_word(REQ_THRUST, 17'd1);
		send_word(REQ_THRUST, 17'h1FFFF);
		send_word(REQ_TICK, 17'd0);
		send_word(REQ_THRUST, 17'd65535);
		send_word(REQ_THRUST, 17'd32768);
		send_word(REQ_THRUST, 17'd98304);
		send_word(REQ_THRUST, 17'd0);
		send_ticks(30);
		settle();

		// Crossed limits, zero tick counts and writes to unused indexes.
		load_config(17'd40000, 17'd20000, 17'h1FF00, 17'h1FF00, 17'h1FF00, 17'h1FF00, 1'b1);
		run_mix(50, 12);
		settle();

		idle_on = 1'b0;
		load_config(17'd0, 17'h1FFFF, 17'd1, 17'd2, 17'd3, 17'h10004, 1'b0);
		run_mix(90, 40);
		settle();
		idle_on = 1'b1;

		load_config(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 131071)),
			17'($urandom_range(1, 6)), 17'($urandom_range(1, 6)),
			17'($urandom_range(1, 6)), 17'($urandom_range(1, 6)), 1'b0);
		pressure_armed = 1'b1;
		run_mix(140, 30);
		settle();

		// Longest zero pulses on a frame that is mostly ones.
		load_config(17'd0, 17'd65536, 17'd255, 17'd255, 17'd1, 17'd2, 1'b0);
		send_word(REQ_THRUST, 17'd1);
		send_ticks(290);
		settle();

		// Longest one pulses; every thrust is raised to full scale.
		load_config(17'd65536, 17'h1FFFF, 17'h1FF01, 17'd1, 17'd255, 17'd255, 1'b0);
		send_word(REQ_THRUST, pick_thrust());
		send_ticks(270);
		settle();

		repeat (6) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
